// ----- design/rusi_pkg.sv -----
// rusi_pkg: widths, stage word types and helpers shared by the ray/unit sphere
// intersection pipeline. No dependencies.
package rusi_pkg;

  localparam int CoordW   = 32;               // coordinate and root width
  localparam int FracW    = 16;               // fraction bits of a coordinate
  localparam int TagW     = 16;               // shape tag width
  localparam int ProdW    = 2 * CoordW;       // one magnitude product
  localparam int SumW     = ProdW;            // sum of three products
  localparam int HalfW    = SumW / 2;         // split for partial products
  localparam int SqW      = 2 * SumW;         // h*h and a*c
  localparam int DW       = SqW + 2;          // discriminant, even width
  localparam int RootW    = DW / 2;           // integer square root
  localparam int RemW     = RootW + 2;        // square root remainder
  localparam int NumW     = RootW + 1;        // |-h +/- s|
  localparam int MW       = NumW + FracW + 2; // 2*num*2^FracW + a
  localparam int DenW     = SumW + 1;         // divisor 2a
  localparam int LimW     = SumW + CoordW + 1;
  localparam int SqrtCells = RootW;
  localparam int DivCells  = CoordW;

  localparam logic [SumW-1:0] One = SumW'(1) << (2 * FracW);

  // Carried alongside the square root chain
  typedef struct packed {
    logic            gn;    // sign of -h
    logic [SumW-1:0] hm;    // |h|
    logic [SumW-1:0] a;
    logic [TagW-1:0] tag;
    logic            keep;  // ray produces a result
  } side_t;

  typedef struct packed {
    logic [DW-1:0]    rad;  // radicand, consumed two bits per cell
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    side_t            side;
  } sqrt_t;

  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic [DenW-1:0]   rem;
    logic [CoordW-1:0] num; // dividend bits still to shift in
    logic [CoordW-1:0] q;
  } root_t;

  typedef struct packed {
    root_t           p;
    root_t           m;
    logic [DenW-1:0] den;
    logic [TagW-1:0] tag;
    logic            keep;
  } div_t;

  function automatic logic [CoordW-1:0] mag_of(input logic [CoordW-1:0] x);
    mag_of = x[CoordW-1] ? (~x + CoordW'(1)) : x;
  endfunction

endpackage

// ----- design/ray_unit_sphere_intersect_top.sv -----
// Ray against unit sphere: front stages, square root chain, divider chain.
// Stages from accepted ray to result word: 7 front, 65 root cells, 3 prep,
// 32 divide cells, 1 output register; rays that miss give no word.
// Throughput one ray per cycle; the pipeline stalls only while its last stage
// holds a hit and the output word waits. Synchronous reset empties all stages.
module ray_unit_sphere_intersect_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [rusi_pkg::CoordW-1:0] origin_x,
  input  logic signed [rusi_pkg::CoordW-1:0] origin_y,
  input  logic signed [rusi_pkg::CoordW-1:0] origin_z,
  input  logic signed [rusi_pkg::CoordW-1:0] dir_x,
  input  logic signed [rusi_pkg::CoordW-1:0] dir_y,
  input  logic signed [rusi_pkg::CoordW-1:0] dir_z,
  input  logic        [rusi_pkg::TagW-1:0]   shape_tag,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rusi_pkg::CoordW-1:0] t_plus,
  output logic signed [rusi_pkg::CoordW-1:0] t_minus,
  output logic        [rusi_pkg::TagW-1:0]   hit_tag,
  output logic                               clipped
);

  localparam int NS = rusi_pkg::SqrtCells;
  localparam int ND = rusi_pkg::DivCells;

  logic            adv;
  logic            sv [NS+1];
  rusi_pkg::sqrt_t sd [NS+1];
  logic            dv [ND+1];
  rusi_pkg::div_t  dd [ND+1];
  logic            load;

  logic [rusi_pkg::CoordW-1:0] vp, vm;

  // hold everything while a finished hit cannot move into the output register
  assign adv      = !(dv[ND] && dd[ND].keep && out_valid && !out_ready);
  assign in_ready = adv;
  assign load     = adv && dv[ND] && dd[ND].keep;

  rusi_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .in_v  (in_valid),
    .ox    (origin_x),
    .oy    (origin_y),
    .oz    (origin_z),
    .ux    (dir_x),
    .uy    (dir_y),
    .uz    (dir_z),
    .tag   (shape_tag),
    .out_v (sv[0]),
    .out_d (sd[0])
  );

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    rusi_sqrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .in_v  (sv[i]),
      .in_d  (sd[i]),
      .out_v (sv[i+1]),
      .out_d (sd[i+1])
    );
  end

  rusi_prep u_prep (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .in_v  (sv[NS]),
    .in_d  (sd[NS]),
    .out_v (dv[0]),
    .out_d (dd[0])
  );

  for (genvar i = 0; i < ND; i++) begin : g_div
    rusi_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .in_v  (dv[i]),
      .in_d  (dd[i]),
      .out_v (dv[i+1]),
      .out_d (dd[i+1])
    );
  end

  always_comb begin
    if (dd[ND].p.ovf) begin
      vp = dd[ND].p.neg ? {1'b1, {(rusi_pkg::CoordW-1){1'b0}}}
                        : {1'b0, {(rusi_pkg::CoordW-1){1'b1}}};
    end else begin
      vp = dd[ND].p.neg ? (~dd[ND].p.q + rusi_pkg::CoordW'(1)) : dd[ND].p.q;
    end
    if (dd[ND].m.ovf) begin
      vm = dd[ND].m.neg ? {1'b1, {(rusi_pkg::CoordW-1){1'b0}}}
                        : {1'b0, {(rusi_pkg::CoordW-1){1'b1}}};
    end else begin
      vm = dd[ND].m.neg ? (~dd[ND].m.q + rusi_pkg::CoordW'(1)) : dd[ND].m.q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      t_plus  <= vp;
      t_minus <= vm;
      hit_tag <= dd[ND].tag;
      clipped <= dd[ND].p.ovf || dd[ND].m.ovf;
    end
  end

`ifndef SYNTHESIS
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sv[NS] |-> ({1'b0, sd[NS].rem} <= (rusi_pkg::RemW+1)'({sd[NS].root, 1'b0})))
    else $error("square root remainder exceeds twice the root");

  a_div_rem_p: assert property (@(posedge clk) disable iff (rst)
    (dv[ND] && dd[ND].keep && !dd[ND].p.ovf) |-> (dd[ND].p.rem < dd[ND].den))
    else $error("t_plus division remainder not below divisor");

  a_div_rem_m: assert property (@(posedge clk) disable iff (rst)
    (dv[ND] && dd[ND].keep && !dd[ND].m.ovf) |-> (dd[ND].m.rem < dd[ND].den))
    else $error("t_minus division remainder not below divisor");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load)
    else $error("output word overwritten while waiting");
`endif

endmodule

// ----- design/rusi_front.sv -----
// rusi_front: splits the ray into magnitudes and forms a, h, c and the
// discriminant h*h - a*c over seven registered stages. Uses rusi_pkg.
module rusi_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_v,
  input  logic [rusi_pkg::CoordW-1:0]   ox,
  input  logic [rusi_pkg::CoordW-1:0]   oy,
  input  logic [rusi_pkg::CoordW-1:0]   oz,
  input  logic [rusi_pkg::CoordW-1:0]   ux,
  input  logic [rusi_pkg::CoordW-1:0]   uy,
  input  logic [rusi_pkg::CoordW-1:0]   uz,
  input  logic [rusi_pkg::TagW-1:0]     tag,
  output logic                          out_v,
  output rusi_pkg::sqrt_t               out_d
);

  logic [6:0] v;

  // stage 1
  logic [rusi_pkg::CoordW-1:0] om [3];
  logic [rusi_pkg::CoordW-1:0] um [3];
  logic [2:0]                  sx1;
  logic [rusi_pkg::TagW-1:0]   tag1;
  // stage 2
  logic [rusi_pkg::ProdW-1:0]  uu [3];
  logic [rusi_pkg::ProdW-1:0]  oo [3];
  logic [rusi_pkg::ProdW-1:0]  uo [3];
  logic [2:0]                  sx2;
  logic [rusi_pkg::TagW-1:0]   tag2;
  // stage 3
  logic [rusi_pkg::SumW-1:0]   a3, oo3, hp3, hn3;
  logic [rusi_pkg::TagW-1:0]   tag3;
  // stage 4
  logic [rusi_pkg::SumW-1:0]   a4, hm4, cm4;
  logic                        gn4, cn4, za4;
  logic [rusi_pkg::TagW-1:0]   tag4;
  // stage 5
  logic [rusi_pkg::ProdW-1:0]  p_hh, p_hl, p_ll, p_ahch, p_ahcl, p_alch, p_alcl;
  logic [rusi_pkg::SumW-1:0]   a5, hm5;
  logic                        gn5, cn5, za5;
  logic [rusi_pkg::TagW-1:0]   tag5;
  // stage 6
  logic [rusi_pkg::SqW-1:0]    h2, ac;
  logic [rusi_pkg::SumW-1:0]   a6, hm6;
  logic                        gn6, cn6, za6;
  logic [rusi_pkg::TagW-1:0]   tag6;

  logic [rusi_pkg::CoordW-1:0] oin [3];
  logic [rusi_pkg::CoordW-1:0] uin [3];

  assign oin[0] = ox;
  assign oin[1] = oy;
  assign oin[2] = oz;
  assign uin[0] = ux;
  assign uin[1] = uy;
  assign uin[2] = uz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        om[k]  <= rusi_pkg::mag_of(oin[k]);
        um[k]  <= rusi_pkg::mag_of(uin[k]);
        sx1[k] <= oin[k][rusi_pkg::CoordW-1] ^ uin[k][rusi_pkg::CoordW-1];
        uu[k]  <= rusi_pkg::ProdW'(um[k]) * rusi_pkg::ProdW'(um[k]);
        oo[k]  <= rusi_pkg::ProdW'(om[k]) * rusi_pkg::ProdW'(om[k]);
        uo[k]  <= rusi_pkg::ProdW'(um[k]) * rusi_pkg::ProdW'(om[k]);
      end
      tag1 <= tag;
      sx2  <= sx1;
      tag2 <= tag1;

      a3   <= uu[0] + uu[1] + uu[2];
      oo3  <= oo[0] + oo[1] + oo[2];
      hp3  <= (sx2[0] ? '0 : uo[0]) + (sx2[1] ? '0 : uo[1]) + (sx2[2] ? '0 : uo[2]);
      hn3  <= (sx2[0] ? uo[0] : '0) + (sx2[1] ? uo[1] : '0) + (sx2[2] ? uo[2] : '0);
      tag3 <= tag2;

      // sign of -h is negative when h is strictly positive
      gn4  <= hp3 > hn3;
      hm4  <= (hp3 > hn3) ? hp3 - hn3 : hn3 - hp3;
      cn4  <= oo3 < rusi_pkg::One;
      cm4  <= (oo3 < rusi_pkg::One) ? rusi_pkg::One - oo3 : oo3 - rusi_pkg::One;
      za4  <= a3 == '0;
      a4   <= a3;
      tag4 <= tag3;

      p_hh   <= rusi_pkg::ProdW'(hm4[rusi_pkg::SumW-1:rusi_pkg::HalfW])
              * rusi_pkg::ProdW'(hm4[rusi_pkg::SumW-1:rusi_pkg::HalfW]);
      p_hl   <= rusi_pkg::ProdW'(hm4[rusi_pkg::SumW-1:rusi_pkg::HalfW])
              * rusi_pkg::ProdW'(hm4[rusi_pkg::HalfW-1:0]);
      p_ll   <= rusi_pkg::ProdW'(hm4[rusi_pkg::HalfW-1:0])
              * rusi_pkg::ProdW'(hm4[rusi_pkg::HalfW-1:0]);
      p_ahch <= rusi_pkg::ProdW'(a4[rusi_pkg::SumW-1:rusi_pkg::HalfW])
              * rusi_pkg::ProdW'(cm4[rusi_pkg::SumW-1:rusi_pkg::HalfW]);
      p_ahcl <= rusi_pkg::ProdW'(a4[rusi_pkg::SumW-1:rusi_pkg::HalfW])
              * rusi_pkg::ProdW'(cm4[rusi_pkg::HalfW-1:0]);
      p_alch <= rusi_pkg::ProdW'(a4[rusi_pkg::HalfW-1:0])
              * rusi_pkg::ProdW'(cm4[rusi_pkg::SumW-1:rusi_pkg::HalfW]);
      p_alcl <= rusi_pkg::ProdW'(a4[rusi_pkg::HalfW-1:0])
              * rusi_pkg::ProdW'(cm4[rusi_pkg::HalfW-1:0]);
      a5   <= a4;
      hm5  <= hm4;
      gn5  <= gn4;
      cn5  <= cn4;
      za5  <= za4;
      tag5 <= tag4;

      h2   <= (rusi_pkg::SqW'(p_hh) << rusi_pkg::SumW)
            + (rusi_pkg::SqW'(p_hl) << (rusi_pkg::HalfW + 1))
            + rusi_pkg::SqW'(p_ll);
      ac   <= (rusi_pkg::SqW'(p_ahch) << rusi_pkg::SumW)
            + (rusi_pkg::SqW'(p_ahcl) << rusi_pkg::HalfW)
            + (rusi_pkg::SqW'(p_alch) << rusi_pkg::HalfW)
            + rusi_pkg::SqW'(p_alcl);
      a6   <= a5;
      hm6  <= hm5;
      gn6  <= gn5;
      cn6  <= cn5;
      za6  <= za5;
      tag6 <= tag5;

      out_d.rad       <= cn6 ? rusi_pkg::DW'(h2) + rusi_pkg::DW'(ac)
                             : rusi_pkg::DW'(h2) - rusi_pkg::DW'(ac);
      out_d.rem       <= '0;
      out_d.root      <= '0;
      out_d.side.gn   <= gn6;
      out_d.side.hm   <= hm6;
      out_d.side.a    <= a6;
      out_d.side.tag  <= tag6;
      // drop zero direction and negative discriminant
      out_d.side.keep <= !za6 && (cn6 || (h2 >= ac));
    end
  end

  assign out_v = v[6];

endmodule

// ----- design/rusi_sqrt_cell.sv -----
// rusi_sqrt_cell: one digit of the integer square root; takes two radicand
// bits and yields one root bit. Uses rusi_pkg.
module rusi_sqrt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_v,
  input  rusi_pkg::sqrt_t in_d,
  output logic            out_v,
  output rusi_pkg::sqrt_t out_d
);

  logic [rusi_pkg::RemW+1:0] t;
  logic [rusi_pkg::RemW+1:0] trial;
  logic                      ge;

  assign t     = {in_d.rem, in_d.rad[rusi_pkg::DW-1 -: 2]};
  assign trial = (rusi_pkg::RemW+2)'({in_d.root, 2'b01});
  assign ge    = t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d.rad  <= {in_d.rad[rusi_pkg::DW-3:0], 2'b00};
      out_d.rem  <= ge ? rusi_pkg::RemW'(t - trial) : rusi_pkg::RemW'(t);
      out_d.root <= {in_d.root[rusi_pkg::RootW-2:0], ge};
      out_d.side <= in_d.side;
    end
  end

endmodule

// ----- design/rusi_prep.sv -----
// rusi_prep: forms both signed root numerators, the scaled dividends and the
// saturation checks, and loads the divider word. Uses rusi_pkg.
module rusi_prep (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_v,
  input  rusi_pkg::sqrt_t in_d,
  output logic            out_v,
  output rusi_pkg::div_t  out_d
);

  logic [2:0] v;

  logic [rusi_pkg::NumW-1:0] hmx, sx, sum, dif;
  logic                      ge;

  logic [rusi_pkg::NumW-1:0] pm1, mm1;
  logic                      pn1, mn1, keep1, keep2;
  logic [rusi_pkg::SumW-1:0] a1, a2;
  logic [rusi_pkg::TagW-1:0] tag1, tag2;
  logic [rusi_pkg::MW-1:0]   mp2, mmv2;
  logic                      pn2, mn2;
  logic [rusi_pkg::LimW-1:0] lim_p, lim_n;

  assign hmx = rusi_pkg::NumW'(in_d.side.hm);
  assign sx  = rusi_pkg::NumW'(in_d.root);
  assign ge  = hmx >= sx;
  assign sum = hmx + sx;
  assign dif = ge ? hmx - sx : sx - hmx;

  assign lim_p = rusi_pkg::LimW'(a2) << rusi_pkg::CoordW;
  assign lim_n = lim_p + (rusi_pkg::LimW'(a2) << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // -h + s and -h - s in sign and magnitude, zero taken as positive
      if (in_d.side.gn) begin
        pm1 <= dif;
        pn1 <= ge && (dif != '0);
        mm1 <= sum;
        mn1 <= sum != '0;
      end else begin
        pm1 <= sum;
        pn1 <= 1'b0;
        mm1 <= dif;
        mn1 <= !ge && (dif != '0);
      end
      a1    <= in_d.side.a;
      tag1  <= in_d.side.tag;
      keep1 <= in_d.side.keep;

      // round to nearest: floor((2n + a) / 2a)
      mp2   <= (rusi_pkg::MW'(pm1) << (rusi_pkg::FracW + 1)) + rusi_pkg::MW'(a1);
      mmv2  <= (rusi_pkg::MW'(mm1) << (rusi_pkg::FracW + 1)) + rusi_pkg::MW'(a1);
      pn2   <= pn1;
      mn2   <= mn1;
      a2    <= a1;
      tag2  <= tag1;
      keep2 <= keep1;

      out_d.p.neg <= pn2;
      out_d.p.ovf <= pn2 ? (rusi_pkg::LimW'(mp2) >= lim_n) : (rusi_pkg::LimW'(mp2) >= lim_p);
      out_d.p.rem <= rusi_pkg::DenW'(mp2[rusi_pkg::MW-1:rusi_pkg::CoordW]);
      out_d.p.num <= mp2[rusi_pkg::CoordW-1:0];
      out_d.p.q   <= '0;
      out_d.m.neg <= mn2;
      out_d.m.ovf <= mn2 ? (rusi_pkg::LimW'(mmv2) >= lim_n) : (rusi_pkg::LimW'(mmv2) >= lim_p);
      out_d.m.rem <= rusi_pkg::DenW'(mmv2[rusi_pkg::MW-1:rusi_pkg::CoordW]);
      out_d.m.num <= mmv2[rusi_pkg::CoordW-1:0];
      out_d.m.q   <= '0;
      out_d.den   <= {a2, 1'b0};
      out_d.tag   <= tag2;
      out_d.keep  <= keep2;
    end
  end

  assign out_v = v[2];

endmodule

// ----- design/rusi_div_cell.sv -----
// rusi_div_cell: one quotient bit of both root divisions (restoring step).
// Uses rusi_pkg.
module rusi_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_v,
  input  rusi_pkg::div_t in_d,
  output logic           out_v,
  output rusi_pkg::div_t out_d
);

  function automatic rusi_pkg::root_t step(input rusi_pkg::root_t r,
                                           input logic [rusi_pkg::DenW-1:0] den);
    logic [rusi_pkg::DenW:0] t;
    logic                    ge;
    rusi_pkg::root_t         o;
    t     = {r.rem, r.num[rusi_pkg::CoordW-1]};
    ge    = t >= {1'b0, den};
    o     = r;
    o.rem = ge ? rusi_pkg::DenW'(t - {1'b0, den}) : rusi_pkg::DenW'(t);
    o.num = {r.num[rusi_pkg::CoordW-2:0], 1'b0};
    o.q   = {r.q[rusi_pkg::CoordW-2:0], ge};
    step  = o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d.p    <= step(in_d.p, in_d.den);
      out_d.m    <= step(in_d.m, in_d.den);
      out_d.den  <= in_d.den;
      out_d.tag  <= in_d.tag;
      out_d.keep <= in_d.keep;
    end
  end

endmodule
